>>> rtl/prl_pkg.sv
// Shared types, constants and key normalization for the peer roster table.
`default_nettype none

package prl_pkg;

  localparam int unsigned KEY_W       = 64;
  localparam int unsigned TIME_W      = 48;
  localparam int unsigned LIM_W       = 4;
  localparam int unsigned SLOT_W      = 3;
  localparam int unsigned COUNT_W     = 4;
  localparam int unsigned IN_FIELD_W  = KEY_W + TIME_W + LIM_W;
  localparam int unsigned IN_TDATA_W  = ((IN_FIELD_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELD_W = SLOT_W + 2 + KEY_W + TIME_W + COUNT_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  typedef enum logic {
    CMD_UPSERT = 1'b0,
    CMD_LIST   = 1'b1
  } cmd_e;

  // Which kind of result the output register loads.
  typedef enum logic [1:0] {
    OUT_UPSERT = 2'd0,
    OUT_LIST   = 2'd1,
    OUT_EMPTY  = 2'd2
  } out_sel_e;

  typedef struct packed {
    logic     accept;     // latch the input beat
    logic     scan_en;    // read issued at rd_addr this cycle
    logic     clr_best;   // restart the per-pass search
    logic     list_mode;  // search for newest instead of oldest
    logic     out_load;   // load the output register
    out_sel_e sel;
    logic     last;       // final beat of a list
  } ctrl_t;

  typedef struct packed {
    logic out_free;       // output register can take a beat this cycle
  } stat_t;

  // Keep only the first nchars characters, stop at the first zero character.
  function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] key,
                                                input int unsigned   nchars);
    logic [KEY_W-1:0] r;
    logic             alive;
    logic [7:0]       c;
    r     = '0;
    alive = 1'b1;
    for (int unsigned i = 0; i < KEY_W / 8; i++) begin
      c     = key[8*i +: 8];
      alive = alive && (c != 8'd0) && (i < nchars);
      if (alive) begin
        r[8*i +: 8] = c;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/peer_roster_lru_table_unit.sv
// Top level of the peer roster table: stream ports, controller and datapath.
//
// Usage:
// - Slave stream takes one command beat: tuser is the command (upsert or
//   list), tdata carries peer key, time and list limit.
// - Master stream returns result beats; tlast marks the final beat of a
//   command. An upsert gives one beat, a list gives min(fill, limit) beats
//   newest first (ties in slot order), or one all-zero beat with count 0.
// - Every command scans the stores one slot per cycle through the RAM read
//   port. Upsert: one pass over the filled slots, then the result is
//   registered. List: each result beat needs one scan pass, which covers
//   only slots 0 to count-1.
// - One command at a time; tready returns high in the cycle after the last
//   result is loaded into the output register, so a new command can enter
//   while that beat still waits for the receiver.
// - A receiver stall holds the output beat steady and stalls the scan
//   sequence before it loads the next beat.
// - Reset empties the table (fill count to zero) and drops any pending beat;
//   store contents need no clearing.
`default_nettype none

module peer_roster_lru_table_unit
  import prl_pkg::*;
#(
  parameter int unsigned ENTRIES   = 8,
  parameter int unsigned KEY_CHARS = 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // tdata: peer_key[63:0], now_us[111:64], limit[115:112], zero pad
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: cmd
  input  wire logic                   s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // tdata: slot[2:0], was_new[3], evicted[4], entry_key[68:5],
  //        heard_us[116:69], count[120:117], zero pad
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                        m_axis_tlast
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  ctrl_t              ctrl;
  stat_t              stat;
  logic [IDX_W-1:0]   rd_addr;
  logic [CNT_W-1:0]   fill;
  logic [CNT_W-1:0]   list_cnt;

  logic [SLOT_W-1:0]  out_slot;
  logic               out_was_new;
  logic               out_evicted;
  logic [KEY_W-1:0]   out_key;
  logic [TIME_W-1:0]  out_heard;
  logic [COUNT_W-1:0] out_count;

  prl_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .fill_i     (fill),
    .list_cnt_i (list_cnt),
    .stat_i     (stat),
    .ctrl_o     (ctrl),
    .rd_addr_o  (rd_addr)
  );

  prl_datapath #(.ENTRIES(ENTRIES), .KEY_CHARS(KEY_CHARS)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .rd_addr_i     (rd_addr),
    .in_key_i      (s_axis_tdata[KEY_W-1:0]),
    .in_now_i      (s_axis_tdata[KEY_W +: TIME_W]),
    .in_limit_i    (s_axis_tdata[KEY_W + TIME_W +: LIM_W]),
    .out_ready_i   (m_axis_tready),
    .stat_o        (stat),
    .fill_o        (fill),
    .list_cnt_o    (list_cnt),
    .out_valid_o   (m_axis_tvalid),
    .out_slot_o    (out_slot),
    .out_was_new_o (out_was_new),
    .out_evicted_o (out_evicted),
    .out_key_o     (out_key),
    .out_heard_o   (out_heard),
    .out_count_o   (out_count),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {(OUT_TDATA_W - OUT_FIELD_W)'(0), out_count, out_heard, out_key,
                         out_evicted, out_was_new, out_slot};

endmodule

`default_nettype wire

>>> rtl/prl_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module prl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/prl_datapath.sv
// Datapath: key/time stores, scan compare, fill count and output register.
`default_nettype none

module prl_datapath
  import prl_pkg::*;
#(
  parameter int unsigned ENTRIES   = 8,
  parameter int unsigned KEY_CHARS = 8,
  localparam int unsigned IDX_W    = $clog2(ENTRIES),
  localparam int unsigned CNT_W    = $clog2(ENTRIES + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ctrl_t             ctrl_i,
  input  wire logic [IDX_W-1:0]  rd_addr_i,
  input  wire logic [KEY_W-1:0]  in_key_i,
  input  wire logic [TIME_W-1:0] in_now_i,
  input  wire logic [LIM_W-1:0]  in_limit_i,
  input  wire logic              out_ready_i,
  output stat_t                  stat_o,
  output logic [CNT_W-1:0]       fill_o,
  output logic [CNT_W-1:0]       list_cnt_o,
  output logic                   out_valid_o,
  output logic [SLOT_W-1:0]      out_slot_o,
  output logic                   out_was_new_o,
  output logic                   out_evicted_o,
  output logic [KEY_W-1:0]       out_key_o,
  output logic [TIME_W-1:0]      out_heard_o,
  output logic [COUNT_W-1:0]     out_count_o,
  output logic                   out_last_o
);

  localparam int unsigned MW = (CNT_W > LIM_W) ? CNT_W : LIM_W;

  logic [KEY_W-1:0]   key_q;
  logic [TIME_W-1:0]  now_q;
  logic [CNT_W-1:0]   list_cnt_q, list_cnt_d;
  logic [CNT_W-1:0]   fill_q;
  logic [ENTRIES-1:0] done_q;

  logic               vld_q;
  logic [IDX_W-1:0]   idx_q;
  logic [KEY_W-1:0]   rkey;
  logic [TIME_W-1:0]  rtime;

  logic               best_vld_q;
  logic [IDX_W-1:0]   best_slot_q;
  logic [KEY_W-1:0]   best_key_q;
  logic [TIME_W-1:0]  best_time_q;
  logic               found_q;
  logic [IDX_W-1:0]   hit_slot_q;

  logic               full;
  logic               wr_en;
  logic [IDX_W-1:0]   wslot;
  logic               take;
  logic               hit;

  logic               out_valid_q;
  logic [SLOT_W-1:0]  slot_q;
  logic               was_new_q;
  logic               evicted_q;
  logic [KEY_W-1:0]   okey_q;
  logic [TIME_W-1:0]  heard_q;
  logic [COUNT_W-1:0] count_q;
  logic               last_q;

  prl_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wslot),
    .wdata_i (key_q),
    .raddr_i (rd_addr_i),
    .rdata_o (rkey)
  );

  prl_ram #(.WIDTH(TIME_W), .DEPTH(ENTRIES)) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wslot),
    .wdata_i (now_q),
    .raddr_i (rd_addr_i),
    .rdata_o (rtime)
  );

  assign full  = (fill_q == CNT_W'(ENTRIES));
  assign wr_en = ctrl_i.out_load && (ctrl_i.sel == OUT_UPSERT);
  // Hit slot, else next free slot, else the oldest entry.
  assign wslot = found_q ? hit_slot_q : (full ? best_slot_q : fill_q[IDX_W-1:0]);

  // List count = min(fill, limit)
  assign list_cnt_d = (MW'(in_limit_i) < MW'(fill_q)) ? CNT_W'(in_limit_i) : fill_q;

  // Ascending scan with strict compares keeps the lowest slot on ties.
  assign take = vld_q && !done_q[idx_q] &&
                (!best_vld_q || (ctrl_i.list_mode ? (rtime > best_time_q)
                                                  : (rtime < best_time_q)));
  assign hit  = vld_q && !ctrl_i.list_mode && !found_q && (rkey == key_q);

  always_ff @(posedge clk_i) begin
    idx_q <= rd_addr_i;
    if (ctrl_i.accept) begin
      key_q      <= norm_key(in_key_i, KEY_CHARS);
      now_q      <= in_now_i;
      list_cnt_q <= list_cnt_d;
    end
    if (take) begin
      best_slot_q <= idx_q;
      best_key_q  <= rkey;
      best_time_q <= rtime;
    end
    if (hit) begin
      hit_slot_q <= idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= 1'b0;
      best_vld_q <= 1'b0;
      found_q    <= 1'b0;
      fill_q     <= '0;
      done_q     <= '0;
    end else begin
      vld_q <= ctrl_i.scan_en;
      if (ctrl_i.clr_best) begin
        best_vld_q <= 1'b0;
      end else if (take) begin
        best_vld_q <= 1'b1;
      end
      if (ctrl_i.accept) begin
        found_q <= 1'b0;
        done_q  <= '0;
      end else if (hit) begin
        found_q <= 1'b1;
      end
      if (wr_en && !found_q && !full) begin
        fill_q <= fill_q + CNT_W'(1);
      end
      if (ctrl_i.out_load && (ctrl_i.sel == OUT_LIST)) begin
        done_q[best_slot_q] <= 1'b1;
      end
    end
  end

  // Output register
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      unique case (ctrl_i.sel)
        OUT_UPSERT: begin
          slot_q    <= SLOT_W'(wslot);
          was_new_q <= !found_q;
          evicted_q <= !found_q && full;
          okey_q    <= key_q;
          heard_q   <= now_q;
          count_q   <= '0;
          last_q    <= 1'b1;
        end
        OUT_LIST: begin
          slot_q    <= SLOT_W'(best_slot_q);
          was_new_q <= 1'b0;
          evicted_q <= 1'b0;
          okey_q    <= best_key_q;
          heard_q   <= best_time_q;
          count_q   <= COUNT_W'(list_cnt_q);
          last_q    <= ctrl_i.last;
        end
        default: begin
          slot_q    <= '0;
          was_new_q <= 1'b0;
          evicted_q <= 1'b0;
          okey_q    <= '0;
          heard_q   <= '0;
          count_q   <= '0;
          last_q    <= 1'b1;
        end
      endcase
    end
  end

  assign fill_o        = fill_q;
  assign list_cnt_o    = list_cnt_q;
  assign out_valid_o   = out_valid_q;
  assign out_slot_o    = slot_q;
  assign out_was_new_o = was_new_q;
  assign out_evicted_o = evicted_q;
  assign out_key_o     = okey_q;
  assign out_heard_o   = heard_q;
  assign out_count_o   = count_q;
  assign out_last_o    = last_q;

endmodule

`default_nettype wire

>>> rtl/prl_ctrl.sv
// Controller FSM: sequences store scans, updates and list emission.
`default_nettype none

module prl_ctrl
  import prl_pkg::*;
#(
  parameter int unsigned ENTRIES = 8,
  localparam int unsigned IDX_W  = $clog2(ENTRIES),
  localparam int unsigned CNT_W  = $clog2(ENTRIES + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             in_cmd_i,
  output logic                  in_ready_o,
  input  wire logic [CNT_W-1:0] fill_i,
  input  wire logic [CNT_W-1:0] list_cnt_i,
  input  wire stat_t            stat_i,
  output ctrl_t                 ctrl_o,
  output logic [IDX_W-1:0]      rd_addr_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_UPD  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  cmd_e             cmd_q, cmd_d;
  logic [CNT_W-1:0] scan_q, scan_d;
  logic [CNT_W-1:0] emit_q, emit_d;
  logic [CNT_W-1:0] bound;
  logic             last_beat;

  assign bound     = (cmd_q == CMD_LIST) ? list_cnt_i : fill_i;
  assign last_beat = ((emit_q + CNT_W'(1)) == list_cnt_i);
  assign rd_addr_o = scan_q[IDX_W-1:0];

  always_comb begin
    state_d          = state_q;
    cmd_d            = cmd_q;
    scan_d           = scan_q;
    emit_d           = emit_q;
    in_ready_o       = 1'b0;
    ctrl_o           = '0;
    ctrl_o.sel       = OUT_UPSERT;
    ctrl_o.list_mode = (cmd_q == CMD_LIST);
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.accept   = 1'b1;
          ctrl_o.clr_best = 1'b1;
          cmd_d           = cmd_e'(in_cmd_i);
          scan_d          = '0;
          emit_d          = '0;
          state_d         = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_q != bound) begin
          ctrl_o.scan_en = 1'b1;
          scan_d         = scan_q + CNT_W'(1);
        end else begin
          state_d = (cmd_q == CMD_LIST) ? ST_EMIT : ST_UPD;
        end
      end
      ST_UPD: begin
        if (stat_i.out_free) begin
          ctrl_o.out_load = 1'b1;
          ctrl_o.sel      = OUT_UPSERT;
          state_d         = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          ctrl_o.out_load = 1'b1;
          if (list_cnt_i == '0) begin
            ctrl_o.sel = OUT_EMPTY;
            state_d    = ST_IDLE;
          end else begin
            ctrl_o.sel  = OUT_LIST;
            ctrl_o.last = last_beat;
            emit_d      = emit_q + CNT_W'(1);
            if (last_beat) begin
              state_d = ST_IDLE;
            end else begin
              ctrl_o.clr_best = 1'b1;
              scan_d          = '0;
              state_d         = ST_SCAN;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cmd_q   <= CMD_UPSERT;
      scan_q  <= '0;
      emit_q  <= '0;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
      scan_q  <= scan_d;
      emit_q  <= emit_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/prl_checker.sv
// Port-level assertions for the peer roster table, bound to the top level.
`default_nettype none

module prl_checker
  import prl_pkg::*;
(
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   s_axis_tvalid,
  input wire logic                   s_axis_tready,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input wire logic                   m_axis_tlast
);

  // Stalled result beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result beat changed while stalled");

  // One command at a time: busy right after a command beat.
  a_busy_after_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("command accepted while previous one in progress");

  // A new-entry flag only comes from an upsert, which is a single final beat.
  a_new_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tlast)
    else $error("was_new on a non-final beat");

  // Eviction only happens when inserting a new key.
  a_evict_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[3])
    else $error("evicted without was_new");

  // Zero count means upsert or empty list: always a single final beat.
  a_zero_count_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[120:117] == 4'd0) |-> m_axis_tlast)
    else $error("zero-count beat without tlast");

endmodule

bind peer_roster_lru_table_unit prl_checker u_prl_checker (.*);

`default_nettype wire
